### rtl/multi_lane_beat_phasor_sequencer_top_macros.svh
// Assertion helpers shared by the sequencer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MULTI_LANE_BEAT_PHASOR_SEQUENCER_TOP_MACROS_SVH
`define MULTI_LANE_BEAT_PHASOR_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define MLBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MLBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MLBPS_ASSERT_IMP(lbl, ante, cons, msg)
`define MLBPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/mlbps_pkg.sv
package mlbps_pkg;

  // Default sizing
  localparam int LANES_DEF = 8;
  localparam int BPL_DEF   = 1024;

  // Field and datapath widths
  localparam int SRW   = 18;  // sample rate
  localparam int MSW   = 16;  // beat length in ms
  localparam int CDW   = 24;  // sample counts and seek position
  localparam int PHW   = 16;  // Q1.15 phase
  localparam int DVDW  = 42;  // divider dividend / quotient
  localparam int DVSW  = 24;  // divider divisor
  localparam int QFRAC = 15;
  localparam int PRW   = MSW + SRW;  // ms times sample rate

  // floor(x / 1000) as floor((x >> 3) * MS_RECIP >> MS_RECIP_SH), exact below 2^34
  localparam logic [31:0] MS_RECIP    = 32'd2199023256;
  localparam int          MS_RECIP_SH = 38;

  localparam logic [SRW-1:0]  SAMPLE_RATE_RST  = 18'd44100;
  localparam logic [CDW-1:0]  BEAT_SAMPLES_RST = 24'd44100;
  localparam logic [CDW-1:0]  CD_MAX           = 24'hFFFFFF;
  localparam logic [PHW-1:0]  DEAD_PHASE       = 16'h8000;
  localparam logic [PHW-1:0]  Q15_MAX          = 16'h7FFF;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_APPEND = 3'd1,
    FN_CLEAR  = 3'd2,
    FN_ARM    = 3'd3,
    FN_PLAY   = 3'd4,
    FN_PAUSE  = 3'd5,
    FN_STOP   = 3'd6,
    FN_SEEK   = 3'd7
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [2:0]       lane;
    logic [MSW-1:0]   beat_ms;
    logic [CDW-1:0]   seek_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            lane_out;
    logic signed [PHW-1:0] phase_out;
    logic                  bang;
    logic                  rejected;
    logic                  last;
  } out_item_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [5:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LANE_FIRST,
    OP_LANE_NEXT,
    OP_HALT,
    OP_PLAY,
    OP_APPEND,
    OP_CLEAR,
    OP_ARM_DEAD,
    OP_POS_ZERO,
    OP_SET_LIVE,
    OP_STOP_LANE,
    OP_RD_POS,
    OP_MUL_BEAT,
    OP_MUL_OFF,
    OP_DIV_MS,
    OP_DIV_Q,
    OP_SET_BEAT,
    OP_SET_OFF,
    OP_TK_ADV,
    OP_TK_DEC,
    OP_RES_Q,
    OP_RES_HELD,
    OP_RES_DEAD,
    OP_RES_BANG,
    OP_HOLD_Q,
    OP_HOLD_DEAD,
    OP_SK_START,
    OP_SK_RD,
    OP_SK_ACC,
    OP_SK_MISS,
    OP_EMIT_RES,
    OP_EMIT_ACK
  } dp_op_t;

  typedef struct packed {
    func_t func;
    logic  ok;
    logic  full;
    logic  cnt_nz;
    logic  alive;
    logic  playing;
    logic  cd_zero;
    logic  div_busy;
    logic  out_free;
    logic  lane_last;
    logic  lane_shown;
    logic  found;
    logic  sk_hit;
    logic  sk_end;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LANE,
    ST_Q_START,
    ST_Q_WAIT,
    ST_TK_EMIT,
    ST_LANE_END,
    ST_LD_RD,
    ST_LD_MUL,
    ST_LD_DIV,
    ST_LD_WAIT,
    ST_LD_DONE,
    ST_OFF_MUL,
    ST_OFF_DIV,
    ST_OFF_WAIT,
    ST_SK_RD,
    ST_SK_ACC,
    ST_SK_MISS,
    ST_ACK
  } ctrl_state_t;

endpackage

### rtl/mlbps_div.sv
module mlbps_div
  import mlbps_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DVDW-1:0] dividend,
  input  logic [DVSW-1:0] divisor,
  output logic            busy,
  output logic [DVDW-1:0] quotient
);

  localparam int CNTW = $clog2(DVDW);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DVDW - 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [DVDW-1:0] q_r;
  logic [DVSW-1:0] rem_r;
  logic [DVSW-1:0] d_r;
  logic [DVSW:0]   sh;
  logic [DVSW:0]   diff;
  logic            ge;

  // One restoring step per cycle, MSB first
  always_comb begin
    sh   = {rem_r, q_r[DVDW-1]};
    diff = sh - {1'b0, d_r};
    ge   = sh >= {1'b0, d_r};
  end

  // Control: run for one step per dividend bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNTW'(1);
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVDW-2:0], ge};
      rem_r <= ge ? diff[DVSW-1:0] : sh[DVSW-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

### rtl/mlbps_datapath.sv
`include "multi_lane_beat_phasor_sequencer_top_macros.svh"
module mlbps_datapath
  import mlbps_pkg::*;
#(
  parameter int LANES          = LANES_DEF,
  parameter int BEATS_PER_LANE = BPL_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  in_item_t       in_data,
  input  logic           cfg_we,
  input  logic [SRW-1:0] cfg_data,
  input  dp_op_t         op,
  output dp_sts_t        sts,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data
);

  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW    = $clog2(BEATS_PER_LANE);
  localparam int CW    = $clog2(BEATS_PER_LANE + 1);
  localparam int AW    = LW + PW;
  localparam int MEMD  = 1 << AW;
  localparam int SHOWN = (LANES < 8) ? LANES : 8;

  // Configuration and captured transaction
  logic [SRW-1:0] sr_r;
  in_item_t       item_r;
  logic           rej_r;

  // Lane state
  logic [LW-1:0]  li_r;
  logic [CW-1:0]  cnt_r  [LANES];
  logic [PW-1:0]  pos_r  [LANES];
  logic [CDW-1:0] cd_r   [LANES];
  logic [CDW-1:0] bs_r   [LANES];
  logic [PHW-1:0] held_r [LANES];
  logic [LANES-1:0] alive_r;
  logic           playing_r;

  // Seek walk
  logic [CDW-1:0] acc_r;
  logic [PW-1:0]  b_r;
  logic           found_r;

  // Beat memory
  logic [MSW-1:0] mem [MEMD];
  logic [MSW-1:0] rdata_r;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           mem_we;
  logic           mem_re;

  // Arithmetic
  logic [MSW-1:0]  mul_a;
  logic [PRW-1:0]  prod_r;
  logic [62:0]     recip_r;
  logic [24:0]     ms_q;
  logic            div_start;
  logic [DVDW-1:0] div_dvd;
  logic [DVSW-1:0] div_dvs;
  logic            div_busy;
  logic [DVDW-1:0] div_q;
  logic [CDW-1:0]  ms_sat;
  logic [PHW-1:0]  q15_val;

  // Result staging and output register
  logic [PHW-1:0] res_r;
  logic           bang_r;
  logic           out_valid_r;
  out_item_t      out_r;

  // Current lane views
  logic [CW-1:0]  cur_cnt;
  logic [PW-1:0]  cur_pos;
  logic [CDW-1:0] cur_cd;
  logic [CDW-1:0] cur_bs;
  logic [CW-1:0]  pos_inc;
  logic [CDW:0]   acc_sum;
  logic           ok;
  logic           full;
  logic           sk_hit;

  always_comb begin
    cur_cnt = cnt_r[li_r];
    cur_pos = pos_r[li_r];
    cur_cd  = cd_r[li_r];
    cur_bs  = bs_r[li_r];
    pos_inc = CW'(cur_pos) + CW'(1);
    acc_sum = {1'b0, acc_r} + (CDW + 1)'(rdata_r);
    sk_hit  = acc_sum > {1'b0, item_r.seek_ms};
    ok      = int'(item_r.lane) < LANES;
    full    = cur_cnt == CW'(BEATS_PER_LANE);
  end

  // Saturate the ms conversion and the Q1.15 quotient
  always_comb begin
    ms_q   = recip_r[62:MS_RECIP_SH];
    ms_sat = ms_q[24] ? CD_MAX : ms_q[CDW-1:0];
    if (cur_bs == '0) begin
      q15_val = '0;
    end else if (|div_q[DVDW-1:QFRAC]) begin
      q15_val = Q15_MAX;
    end else begin
      q15_val = {1'b0, div_q[QFRAC-1:0]};
    end
  end

  // Sample rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      sr_r <= cfg_data;
    end
  end

  // Capture transaction and track reject flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r <= 1'b0;
    end else if (op == OP_CAPTURE) begin
      rej_r <= 1'b0;
    end else if (op == OP_APPEND && (!ok || full)) begin
      rej_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_CAPTURE) begin
      item_r <= in_data;
    end
  end

  // Lane index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r <= '0;
    end else begin
      case (op)
        OP_CAPTURE:                li_r <= LW'(in_data.lane);
        OP_LANE_FIRST, OP_HALT:    li_r <= '0;
        OP_LANE_NEXT:              li_r <= li_r + LW'(1);
        default:                   li_r <= li_r;
      endcase
    end
  end

  // Transport
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
    end else if (op == OP_PLAY) begin
      playing_r <= 1'b1;
    end else if (op == OP_HALT) begin
      playing_r <= 1'b0;
    end
  end

  // Per-lane state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        cnt_r[i]  <= '0;
        pos_r[i]  <= '0;
        cd_r[i]   <= BEAT_SAMPLES_RST;
        bs_r[i]   <= BEAT_SAMPLES_RST;
        held_r[i] <= '0;
      end
      alive_r <= '0;
    end else begin
      case (op)
        OP_APPEND: begin
          if (ok && !full) begin
            cnt_r[li_r] <= cur_cnt + CW'(1);
          end
        end
        OP_CLEAR: begin
          if (ok) begin
            cnt_r[li_r]   <= '0;
            pos_r[li_r]   <= '0;
            alive_r[li_r] <= 1'b0;
          end
        end
        OP_ARM_DEAD: alive_r[li_r] <= 1'b0;
        OP_POS_ZERO: pos_r[li_r]   <= '0;
        OP_SET_LIVE: alive_r[li_r] <= 1'b1;
        OP_STOP_LANE: begin
          held_r[li_r] <= '0;
          if (alive_r[li_r] && cur_cnt != '0) begin
            pos_r[li_r] <= '0;
          end
        end
        OP_SET_BEAT: begin
          bs_r[li_r] <= ms_sat;
          cd_r[li_r] <= ms_sat;
        end
        OP_SET_OFF: begin
          cd_r[li_r]    <= (cur_bs > ms_sat) ? cur_bs - ms_sat : '0;
          alive_r[li_r] <= 1'b1;
        end
        OP_TK_ADV: begin
          if (pos_inc < cur_cnt) begin
            pos_r[li_r] <= pos_inc[PW-1:0];
          end else begin
            pos_r[li_r]   <= '0;
            alive_r[li_r] <= 1'b0;
          end
        end
        OP_TK_DEC:    cd_r[li_r]   <= cur_cd - CDW'(1);
        OP_HOLD_Q:    held_r[li_r] <= q15_val;
        OP_HOLD_DEAD: held_r[li_r] <= DEAD_PHASE;
        OP_SK_ACC: begin
          if (sk_hit) begin
            pos_r[li_r] <= b_r;
          end
        end
        OP_SK_MISS: begin
          alive_r[li_r] <= 1'b0;
          pos_r[li_r]   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Seek walk: accumulate beat ends until one passes the position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (op == OP_SK_START) begin
      found_r <= 1'b0;
    end else if (op == OP_SK_ACC && sk_hit) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_SK_START) begin
      acc_r <= '0;
      b_r   <= '0;
    end else if (op == OP_SK_ACC && !sk_hit) begin
      acc_r <= acc_sum[CDW-1:0];
      b_r   <= b_r + PW'(1);
    end
  end

  // Beat memory, one write and one registered read port
  always_comb begin
    mem_we = (op == OP_APPEND) && ok && !full;
    mem_re = (op == OP_RD_POS) || (op == OP_SK_RD);
    waddr  = {li_r, cur_cnt[PW-1:0]};
    raddr  = {li_r, (op == OP_SK_RD) ? b_r : cur_pos};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= item_r.beat_ms;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Multiply milliseconds by sample rate; the seek offset is shorter than its beat
  assign mul_a = (op == OP_MUL_BEAT) ? rdata_r : MSW'(item_r.seek_ms - acc_r);

  always_ff @(posedge clk) begin
    if (op == OP_MUL_BEAT || op == OP_MUL_OFF) begin
      prod_r <= PRW'(mul_a) * PRW'(sr_r);
    end
  end

  // Divide the product by 1000 through a reciprocal of 125 after a shift by 3
  always_ff @(posedge clk) begin
    if (op == OP_DIV_MS) begin
      recip_r <= 63'(prod_r[PRW-1:3]) * 63'(MS_RECIP);
    end
  end

  // Serial divider for the Q1.15 phase
  always_comb begin
    div_start = (op == OP_DIV_Q);
    div_dvd   = {{(DVDW - CDW - QFRAC){1'b0}}, cur_cd, {QFRAC{1'b0}}};
    div_dvs   = cur_bs;
  end

  mlbps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Stage the lane result
  always_ff @(posedge clk) begin
    case (op)
      OP_RES_Q: begin
        res_r  <= q15_val;
        bang_r <= 1'b0;
      end
      OP_RES_HELD: begin
        res_r  <= held_r[li_r];
        bang_r <= 1'b0;
      end
      OP_RES_DEAD: begin
        res_r  <= DEAD_PHASE;
        bang_r <= 1'b0;
      end
      OP_RES_BANG: begin
        res_r  <= '0;
        bang_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT_RES || op == OP_EMIT_ACK) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT_RES) begin
      out_r.lane_out  <= 3'(li_r);
      out_r.phase_out <= res_r;
      out_r.bang      <= bang_r;
      out_r.rejected  <= 1'b0;
      out_r.last      <= int'(li_r) == SHOWN - 1;
    end else if (op == OP_EMIT_ACK) begin
      out_r.lane_out  <= '0;
      out_r.phase_out <= '0;
      out_r.bang      <= 1'b0;
      out_r.rejected  <= rej_r;
      out_r.last      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller
  always_comb begin
    sts.func       = item_r.func;
    sts.ok         = ok;
    sts.full       = full;
    sts.cnt_nz     = cur_cnt != '0;
    sts.alive      = alive_r[li_r];
    sts.playing    = playing_r;
    sts.cd_zero    = cur_cd == '0;
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || out_ready;
    sts.lane_last  = int'(li_r) == LANES - 1;
    sts.lane_shown = int'(li_r) < SHOWN;
    sts.found      = found_r;
    sts.sk_hit     = sk_hit;
    sts.sk_end     = (CW'(b_r) + CW'(1)) == cur_cnt;
  end

  `MLBPS_ASSERT_IMP(a_play_fall, ($fell(playing_r) && $past(rst_n)), $past(op == OP_HALT), "transport stopped without a halt")
  `MLBPS_ASSERT_NXT(a_capture_rej, (op == OP_CAPTURE), !rej_r, "reject flag not cleared on capture")
  `MLBPS_ASSERT_NXT(a_emit_valid, (op == OP_EMIT_RES || op == OP_EMIT_ACK), out_valid_r, "emitted result not valid")

endmodule

### rtl/mlbps_ctrl.sv
`include "multi_lane_beat_phasor_sequencer_top_macros.svh"
module mlbps_ctrl
  import mlbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_op_t  op
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.func)
          FN_TICK, FN_PAUSE, FN_STOP, FN_SEEK: state_nxt = ST_LANE;
          FN_ARM: begin
            if (sts.ok && sts.cnt_nz) state_nxt = ST_LD_RD;
            else state_nxt = ST_ACK;
          end
          default: state_nxt = ST_ACK;
        endcase
      end
      ST_LANE: begin
        case (sts.func)
          FN_TICK: begin
            if (!sts.playing || !sts.alive) state_nxt = ST_TK_EMIT;
            else if (sts.cd_zero) state_nxt = ST_LD_RD;
            else state_nxt = ST_Q_START;
          end
          FN_PAUSE: state_nxt = sts.alive ? ST_Q_START : ST_LANE_END;
          FN_STOP:  state_nxt = (sts.alive && sts.cnt_nz) ? ST_LD_RD : ST_LANE_END;
          FN_SEEK:  state_nxt = sts.cnt_nz ? ST_SK_RD : ST_LANE_END;
          default:  state_nxt = ST_ACK;
        endcase
      end
      ST_Q_START: state_nxt = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = (sts.func == FN_TICK) ? ST_TK_EMIT : ST_LANE_END;
        end
      end
      ST_TK_EMIT: begin
        if (!sts.lane_shown || sts.out_free) state_nxt = ST_LANE_END;
      end
      ST_LANE_END: begin
        if (!sts.lane_last) state_nxt = ST_LANE;
        else if (sts.func == FN_TICK) state_nxt = ST_IDLE;
        else state_nxt = ST_ACK;
      end
      ST_LD_RD:  state_nxt = ST_LD_MUL;
      ST_LD_MUL: state_nxt = ST_LD_DIV;
      ST_LD_DIV: state_nxt = ST_LD_WAIT;
      ST_LD_WAIT: begin
        if (!sts.div_busy) state_nxt = ST_LD_DONE;
      end
      ST_LD_DONE: begin
        case (sts.func)
          FN_TICK: state_nxt = ST_TK_EMIT;
          FN_ARM:  state_nxt = ST_ACK;
          FN_SEEK: state_nxt = sts.found ? ST_OFF_MUL : ST_LANE_END;
          default: state_nxt = ST_LANE_END;
        endcase
      end
      ST_OFF_MUL: state_nxt = ST_OFF_DIV;
      ST_OFF_DIV: state_nxt = ST_OFF_WAIT;
      ST_OFF_WAIT: begin
        if (!sts.div_busy) state_nxt = ST_LANE_END;
      end
      ST_SK_RD: state_nxt = ST_SK_ACC;
      ST_SK_ACC: begin
        if (sts.sk_hit) state_nxt = ST_LD_RD;
        else if (sts.sk_end) state_nxt = ST_SK_MISS;
        else state_nxt = ST_SK_RD;
      end
      ST_SK_MISS: state_nxt = ST_LD_RD;
      ST_ACK: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath operation
  always_comb begin
    op = OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) op = OP_CAPTURE;
      end
      ST_DISPATCH: begin
        case (sts.func)
          FN_TICK, FN_SEEK:  op = OP_LANE_FIRST;
          FN_PAUSE, FN_STOP: op = OP_HALT;
          FN_APPEND:         op = OP_APPEND;
          FN_CLEAR:          op = OP_CLEAR;
          FN_PLAY:           op = OP_PLAY;
          FN_ARM: begin
            if (sts.ok) op = sts.cnt_nz ? OP_POS_ZERO : OP_ARM_DEAD;
          end
          default: op = OP_NOP;
        endcase
      end
      ST_LANE: begin
        case (sts.func)
          FN_TICK: begin
            if (!sts.playing) op = OP_RES_HELD;
            else if (!sts.alive) op = OP_RES_DEAD;
            else if (sts.cd_zero) op = OP_TK_ADV;
            else op = OP_TK_DEC;
          end
          FN_PAUSE: begin
            if (!sts.alive) op = OP_HOLD_DEAD;
          end
          FN_STOP: op = OP_STOP_LANE;
          FN_SEEK: op = sts.cnt_nz ? OP_SK_START : OP_SK_MISS;
          default: op = OP_NOP;
        endcase
      end
      ST_Q_START: op = OP_DIV_Q;
      ST_Q_WAIT: begin
        if (!sts.div_busy) op = (sts.func == FN_TICK) ? OP_RES_Q : OP_HOLD_Q;
      end
      ST_TK_EMIT: begin
        if (sts.lane_shown && sts.out_free) op = OP_EMIT_RES;
      end
      ST_LANE_END: begin
        if (!sts.lane_last) op = OP_LANE_NEXT;
      end
      ST_LD_RD:  op = OP_RD_POS;
      ST_LD_MUL: op = OP_MUL_BEAT;
      ST_LD_DIV: op = OP_DIV_MS;
      ST_LD_WAIT: begin
        if (!sts.div_busy) op = OP_SET_BEAT;
      end
      ST_LD_DONE: begin
        case (sts.func)
          FN_TICK: op = OP_RES_BANG;
          FN_ARM:  op = OP_SET_LIVE;
          default: op = OP_NOP;
        endcase
      end
      ST_OFF_MUL: op = OP_MUL_OFF;
      ST_OFF_DIV: op = OP_DIV_MS;
      ST_OFF_WAIT: begin
        if (!sts.div_busy) op = OP_SET_OFF;
      end
      ST_SK_RD:   op = OP_SK_RD;
      ST_SK_ACC:  op = OP_SK_ACC;
      ST_SK_MISS: op = OP_SK_MISS;
      ST_ACK: begin
        if (sts.out_free) op = OP_EMIT_ACK;
      end
      default: op = OP_NOP;
    endcase
  end

  assign in_ready = state_r == ST_IDLE;

  `MLBPS_ASSERT_IMP(a_div_idle, (op == OP_DIV_MS || op == OP_DIV_Q), !sts.div_busy, "divider started while busy")
  `MLBPS_ASSERT_IMP(a_emit_free, (op == OP_EMIT_RES || op == OP_EMIT_ACK), sts.out_free, "result emitted over a pending one")
  `MLBPS_ASSERT_NXT(a_accept_dispatch, (in_valid && in_ready), (state_r == ST_DISPATCH), "accepted transaction not dispatched")

endmodule

### rtl/multi_lane_beat_phasor_sequencer_top.sv
// One transaction at a time; append, clear, play and arm of an empty lane act at dispatch and
// then give their result. Arm with beats first reads, scales and loads beat 0 of its lane.
// Tick: a paused or dead lane gives its held or dead phase, a counting lane runs the 42-step
// Q1.15 division and a lane at a beat end loads its next beat; each result waits for the output.
// Pause holds the phase of each live lane, stop reloads each live lane with beats, seek scans beats.
// Reset (rst_n low, synchronous) empties all lanes and pauses; beat memory is not cleared.
module multi_lane_beat_phasor_sequencer_top
  import mlbps_pkg::*;
#(
  parameter int LANES          = LANES_DEF,
  parameter int BEATS_PER_LANE = BPL_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data,
  input  logic           cfg_we,
  input  logic [SRW-1:0] cfg_data
);

  dp_op_t  op;
  dp_sts_t sts;

  // Sequence each transaction through the datapath
  mlbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  // Lane state, beat memory, arithmetic and output register
  mlbps_datapath #(
    .LANES          (LANES),
    .BEATS_PER_LANE (BEATS_PER_LANE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .op        (op),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/mlbps_scoreboard.sv
module mlbps_scoreboard
  import mlbps_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  in_item_t       in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  out_item_t      out_data,
  input  logic           cfg_we,
  input  logic [SRW-1:0] cfg_data,
  output int             errors,
  output int             pending,
  output int             results_seen
);

  localparam int NL  = 8;
  localparam int BPL = 1024;

  // Sequencer state mirror
  logic [SRW-1:0] rate;
  logic [MSW-1:0] beats [NL][BPL];
  int unsigned    n_beats [NL];
  int unsigned    pos [NL];
  logic [CDW-1:0] cdown [NL];
  logic [CDW-1:0] blen [NL];
  logic           live [NL];
  logic [PHW-1:0] held [NL];
  logic           running;

  out_item_t phase_q[$];

  assign pending = phase_q.size();

  function automatic logic [CDW-1:0] to_samples(logic [31:0] ms);
    logic [63:0] p;
    p = (64'(ms) * 64'(rate)) / 64'd1000;
    if (p > 64'hFFFFFF) p = 64'hFFFFFF;
    return p[CDW-1:0];
  endfunction

  function automatic logic [PHW-1:0] frac_q15(logic [CDW-1:0] c, logic [CDW-1:0] len);
    logic [63:0] q;
    if (len == 0) return '0;
    q = (64'(c) << QFRAC) / 64'(len);
    if (q > 64'd32767) q = 64'd32767;
    return q[PHW-1:0];
  endfunction

  function automatic void load(int l, int unsigned p);
    pos[l]   = p;
    blen[l]  = to_samples(32'(beats[l][p]));
    cdown[l] = blen[l];
  endfunction

  function automatic void reset_state();
    rate = SAMPLE_RATE_RST;
    running = 1'b0;
    for (int l = 0; l < NL; l++) begin
      n_beats[l] = 0;
      pos[l] = 0;
      cdown[l] = BEAT_SAMPLES_RST;
      blen[l] = BEAT_SAMPLES_RST;
      live[l] = 1'b0;
      held[l] = '0;
    end
  endfunction

  // Advance the mirror by one command and queue the results it produces
  function automatic void predict(in_item_t it);
    out_item_t r;
    logic [PHW-1:0] ph;
    logic bng;
    logic rej;
    logic [31:0] acc, prev;
    logic hit;
    logic [CDW-1:0] off;
    int l;
    rej = 1'b0;
    l = it.lane;
    case (it.func)
      FN_TICK: begin
        for (int k = 0; k < NL; k++) begin
          bng = 1'b0;
          if (!running) begin
            ph = held[k];
          end else if (!live[k]) begin
            ph = DEAD_PHASE;
          end else if (cdown[k] == 0) begin
            if (pos[k] + 1 < n_beats[k]) begin
              load(k, pos[k] + 1);
            end else begin
              load(k, 0);
              live[k] = 1'b0;
            end
            bng = 1'b1;
            ph = '0;
          end else begin
            cdown[k] = cdown[k] - 1;
            ph = frac_q15(cdown[k], blen[k]);
          end
          r.lane_out = 3'(k);
          r.phase_out = ph;
          r.bang = bng;
          r.rejected = 1'b0;
          r.last = (k == NL - 1);
          phase_q.push_back(r);
        end
        return;
      end
      FN_APPEND: begin
        if (n_beats[l] >= BPL) begin
          rej = 1'b1;
        end else begin
          beats[l][n_beats[l]] = it.beat_ms;
          n_beats[l]++;
        end
      end
      FN_CLEAR: begin
        n_beats[l] = 0;
        pos[l] = 0;
        live[l] = 1'b0;
      end
      FN_ARM: begin
        if (n_beats[l] > 0) begin
          load(l, 0);
          live[l] = 1'b1;
        end else begin
          live[l] = 1'b0;
        end
      end
      FN_PLAY: running = 1'b1;
      FN_PAUSE: begin
        running = 1'b0;
        for (int k = 0; k < NL; k++)
          held[k] = live[k] ? frac_q15(cdown[k], blen[k]) : DEAD_PHASE;
      end
      FN_STOP: begin
        running = 1'b0;
        for (int k = 0; k < NL; k++) begin
          held[k] = '0;
          if (live[k] && n_beats[k] > 0) load(k, 0);
        end
      end
      default: begin
        for (int k = 0; k < NL; k++) begin
          acc = 0;
          prev = 0;
          hit = 1'b0;
          for (int unsigned b = 0; b < n_beats[k]; b++) begin
            acc += 32'(beats[k][b]);
            if (acc > 32'(it.seek_ms)) begin
              load(k, b);
              off = to_samples(32'(it.seek_ms) - prev);
              cdown[k] = blen[k] > off ? blen[k] - off : '0;
              live[k] = 1'b1;
              hit = 1'b1;
              break;
            end
            prev = acc;
          end
          if (!hit) begin
            live[k] = 1'b0;
            if (n_beats[k] > 0) load(k, 0);
            else pos[k] = 0;
          end
        end
      end
    endcase
    r = '0;
    r.rejected = rej;
    r.last = 1'b1;
    phase_q.push_back(r);
  endfunction

  // Track commands and config, compare each result transaction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      reset_state();
      phase_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) rate = cfg_data;
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (phase_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          exp_r = phase_q.pop_front();
          if (out_data.lane_out !== exp_r.lane_out || out_data.phase_out !== exp_r.phase_out ||
              out_data.bang !== exp_r.bang || out_data.rejected !== exp_r.rejected ||
              out_data.last !== exp_r.last) begin
            errors++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, out_data);
          end
        end
      end
    end
  end

endmodule

### tb/sv/tb_multi_lane_beat_phasor_sequencer_top.sv
module tb_multi_lane_beat_phasor_sequencer_top;
  import mlbps_pkg::*;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  in_item_t       in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_item_t      out_data;
  logic           cfg_we = 1'b0;
  logic [SRW-1:0] cfg_data = '0;

  int errors, pending, results_seen;
  int send_idle_pct, recv_idle_pct;
  int n_cmds;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_lane_beat_phasor_sequencer_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  mlbps_scoreboard u_sb (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one command transaction and hold it until accepted
  task automatic issue(func_t f, logic [2:0] ln, logic [MSW-1:0] ms, logic [CDW-1:0] sk);
    in_item_t it;
    it.func = f;
    it.lane = ln;
    it.beat_ms = ms;
    it.seek_ms = sk;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_cmds++;
  endtask

  // Drain all results, let the block settle, then write the sample rate
  task automatic set_rate(logic [SRW-1:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd();
    int pick;
    logic [MSW-1:0] ms;
    logic [CDW-1:0] sk;
    pick = $urandom_range(99);
    ms = ($urandom_range(9) == 0) ? MSW'($urandom) : MSW'($urandom_range(3));
    sk = ($urandom_range(9) == 0) ? CDW'($urandom) : CDW'($urandom_range(12));
    if (pick < 45)      issue(FN_TICK, 3'($urandom), ms, sk);
    else if (pick < 63) issue(FN_APPEND, 3'($urandom), ms, sk);
    else if (pick < 73) issue(FN_ARM, 3'($urandom), ms, sk);
    else if (pick < 76) issue(FN_CLEAR, 3'($urandom), ms, sk);
    else if (pick < 84) issue(FN_PLAY, 3'($urandom), ms, sk);
    else if (pick < 88) issue(FN_PAUSE, 3'($urandom), ms, sk);
    else if (pick < 91) issue(FN_STOP, 3'($urandom), ms, sk);
    else                issue(FN_SEEK, 3'($urandom), ms, sk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_cmds = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: paused and dead ticks, a short lane playing through, pause, stop, seek
    issue(FN_TICK, 3'd0, '0, '0);
    issue(FN_ARM, 3'd3, '0, '0);
    issue(FN_PLAY, 3'd0, '0, '0);
    issue(FN_TICK, 3'd0, '0, '0);
    issue(FN_APPEND, 3'd0, 16'd0, '0);
    issue(FN_APPEND, 3'd0, 16'd1, '0);
    issue(FN_APPEND, 3'd1, 16'hFFFF, '0);
    issue(FN_ARM, 3'd0, '0, '0);
    issue(FN_ARM, 3'd1, '0, '0);
    set_rate(18'd8000);
    issue(FN_ARM, 3'd0, '0, '0);
    issue(FN_PLAY, 3'd0, '0, '0);
    repeat (4) issue(FN_TICK, 3'd0, '0, '0);
    issue(FN_PAUSE, 3'd0, '0, '0);
    issue(FN_TICK, 3'd0, '0, '0);
    issue(FN_STOP, 3'd0, '0, '0);
    issue(FN_TICK, 3'd0, '0, '0);
    issue(FN_SEEK, 3'd0, '0, 24'd0);
    issue(FN_SEEK, 3'd0, '0, 24'hFFFFFF);
    issue(FN_SEEK, 3'd0, '0, 24'hA5A5A5);

    // Load a lane, seek into it, then empty it and arm it empty
    for (int i = 0; i < 6; i++) issue(FN_APPEND, 3'd7, MSW'($urandom_range(2)), '0);
    issue(FN_SEEK, 3'd0, '0, 24'd3);
    issue(FN_CLEAR, 3'd7, '0, '0);
    issue(FN_ARM, 3'd7, '0, '0);
    issue(FN_TICK, 3'd0, '0, '0);

    // Random phases with different stall mixes and sample rates
    set_rate(18'd192000);
    send_idle_pct = 31;
    recv_idle_pct = 85;
    repeat (90) random_cmd();
    set_rate(SRW'($urandom_range(192000, 8000)));
    send_idle_pct = 85;
    recv_idle_pct = 31;
    repeat (90) random_cmd();
    set_rate(18'd8000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (90) random_cmd();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("covered %0d commands and %0d results over three stall mixes and four rates",
             n_cmds, results_seen);
    $display("including seeks at both ends of the range and arming an emptied lane");
    if (errors == 0) begin
      $display("tb_multi_lane_beat_phasor_sequencer_top: done, clean");
    end else begin
      $display("tb_multi_lane_beat_phasor_sequencer_top: done, errors");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #40000000;
    $display("tb_multi_lane_beat_phasor_sequencer_top: done, errors");
    $finish;
  end

endmodule
